### rtl/ils_pkg.sv
package ils_pkg;

    localparam int ILS_DEPTH = 64;
    localparam int ILS_AW    = $clog2(ILS_DEPTH);
    localparam int ILS_CW    = $clog2(ILS_DEPTH + 1);
    localparam int ILS_CMPW  = (ILS_CW > 7) ? ILS_CW : 7;

    localparam int ILS_DW    = 32;
    localparam int ILS_KW    = 3;
    localparam int ILS_PW    = 7;
    localparam int ILS_SW    = 3;
    localparam int ILS_NW    = 7;

    typedef enum logic [ILS_KW-1:0] {
        K_PUSH_FRONT = 3'd0,
        K_PUSH_REAR  = 3'd1,
        K_INSERT_AT  = 3'd2,
        K_POP_FRONT  = 3'd3,
        K_POP_REAR   = 3'd4,
        K_REMOVE_AT  = 3'd5,
        K_FIND       = 3'd6
    } t_kind;

    typedef enum logic [ILS_SW-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_BAD_POS   = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_INS  = 2'd1,
        OP_REM  = 2'd2,
        OP_FIND = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_READ,
        S_DRAIN,
        S_PLACE,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic start;
        logic rd;
        logic place;
        logic commit_rem;
        logic out_load;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic skip;
        t_op  dec_op;
        logic no_moves;
        t_op  op;
        logic last;
    } t_dp_stat;

endpackage

### rtl/ils_ram.sv
module ils_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/ils_ctrl.sv
module ils_ctrl
    import ils_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    output logic     o_s_tready,
    input  logic     i_m_tready,
    output logic     o_m_tvalid,
    input  t_dp_stat i_stat,
    output t_cmd     o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_stat.skip) n_state = S_DONE;
                else if (i_stat.dec_op == OP_INS && i_stat.no_moves) n_state = S_PLACE;
                else n_state = S_READ;
            end
            S_READ: begin
                if (i_stat.last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = (i_stat.op == OP_INS) ? S_PLACE : S_DONE;
            end
            S_PLACE: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        n_out_valid = r_out_valid && !i_m_tready;
        case (r_state)
            S_IDLE:   o_cmd.load  = i_s_tvalid;
            S_DECIDE: o_cmd.start = 1'b1;
            S_READ:   o_cmd.rd    = 1'b1;
            S_DRAIN:  o_cmd.commit_rem = (i_stat.op == OP_REM);
            S_PLACE:  o_cmd.place = 1'b1;
            S_DONE: begin
                o_cmd.out_load = out_free;
                if (out_free) n_out_valid = 1'b1;
            end
            default: o_cmd = '0;
        endcase
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;

endmodule

### rtl/ils_dp.sv
module ils_dp
    import ils_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_dp_stat          o_stat,
    input  logic [ILS_KW-1:0] i_kind,
    input  logic [ILS_PW-1:0] i_position,
    input  logic [ILS_DW-1:0] i_value,
    output logic [ILS_DW-1:0] o_result_value,
    output logic [ILS_SW-1:0] o_status,
    output logic [ILS_NW-1:0] o_entry_count,
    output logic              o_mem_we,
    output logic [ILS_AW-1:0] o_mem_waddr,
    output logic [ILS_DW-1:0] o_mem_wdata,
    output logic              o_mem_re,
    output logic [ILS_AW-1:0] o_mem_raddr,
    input  logic [ILS_DW-1:0] i_mem_rdata
);

    logic [ILS_KW-1:0]   r_kind;
    logic [ILS_PW-1:0]   r_pos;
    logic [ILS_DW-1:0]   r_value;
    logic [ILS_CW-1:0]   r_count;
    t_op                 r_op;
    logic [ILS_CMPW-1:0] r_epos;
    logic [ILS_AW-1:0]   r_addr;
    logic [ILS_AW-1:0]   r_rd_a;
    logic                r_rd_v;
    logic                r_found;
    logic [ILS_DW-1:0]   r_result;
    t_status             r_status;
    logic [ILS_DW-1:0]   r_out_value;
    logic [ILS_SW-1:0]   r_out_status;
    logic [ILS_NW-1:0]   r_out_count;

    logic [ILS_CMPW-1:0] cnt;
    logic [ILS_CMPW-1:0] cnt_m1;
    logic [ILS_CMPW-1:0] pos;
    logic [ILS_CMPW-1:0] addr_ext;
    logic                full;
    logic                empty;
    t_op                 dec_op;
    t_status             dec_status;
    logic [ILS_CMPW-1:0] dec_epos;
    logic [ILS_AW-1:0]   init_addr;
    logic                rem_hit;

    assign cnt      = ILS_CMPW'(r_count);
    assign cnt_m1   = cnt - ILS_CMPW'(1);
    assign pos      = ILS_CMPW'(r_pos);
    assign addr_ext = ILS_CMPW'(r_addr);
    assign full     = (cnt >= ILS_CMPW'(ILS_DEPTH));
    assign empty    = (cnt == '0);

    // command decode against the current count
    always_comb begin
        dec_op     = OP_NONE;
        dec_status = ST_OK;
        dec_epos   = '0;
        case (r_kind)
            K_PUSH_FRONT: begin
                dec_op = OP_INS;
                if (full) dec_status = ST_FULL;
            end
            K_PUSH_REAR: begin
                dec_op   = OP_INS;
                dec_epos = cnt;
                if (full) dec_status = ST_FULL;
            end
            K_INSERT_AT: begin
                dec_op   = OP_INS;
                dec_epos = pos;
                if (pos > cnt) dec_status = ST_BAD_POS;
                else if (full) dec_status = ST_FULL;
            end
            K_POP_FRONT: begin
                dec_op = OP_REM;
                if (empty) dec_status = ST_EMPTY;
            end
            K_POP_REAR: begin
                dec_op   = OP_REM;
                dec_epos = cnt_m1;
                if (empty) dec_status = ST_EMPTY;
            end
            K_REMOVE_AT: begin
                dec_op   = OP_REM;
                dec_epos = pos;
                if (empty) dec_status = ST_EMPTY;
                else if (pos >= cnt) dec_status = ST_BAD_POS;
            end
            K_FIND: begin
                dec_op     = OP_FIND;
                dec_status = ST_NOT_FOUND;
            end
            default: begin
                dec_op = OP_NONE;
            end
        endcase
    end

    always_comb begin
        case (dec_op)
            OP_INS:  init_addr = cnt_m1[ILS_AW-1:0];
            OP_REM:  init_addr = dec_epos[ILS_AW-1:0];
            default: init_addr = '0;
        endcase
    end

    assign o_stat.skip     = (dec_op == OP_NONE)
                          || (dec_op == OP_FIND && empty)
                          || (dec_op != OP_FIND && dec_status != ST_OK);
    assign o_stat.dec_op   = dec_op;
    assign o_stat.no_moves = (dec_epos == cnt);
    assign o_stat.op       = r_op;
    assign o_stat.last     = (r_op == OP_INS) ? (addr_ext == r_epos) : (addr_ext == cnt_m1);

    assign rem_hit = (ILS_CMPW'(r_rd_a) == r_epos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_rd_v  <= 1'b0;
        end else begin
            r_rd_v <= i_cmd.rd;
            if (i_cmd.place) r_count <= r_count + ILS_CW'(1);
            if (i_cmd.commit_rem) r_count <= r_count - ILS_CW'(1);
        end

        if (i_cmd.load) begin
            r_kind  <= i_kind;
            r_pos   <= i_position;
            r_value <= i_value;
        end

        if (i_cmd.start) begin
            r_op     <= dec_op;
            r_epos   <= dec_epos;
            r_addr   <= init_addr;
            r_status <= dec_status;
            r_result <= '0;
            r_found  <= 1'b0;
        end

        if (i_cmd.rd) begin
            r_rd_a <= r_addr;
            r_addr <= (r_op == OP_INS) ? r_addr - ILS_AW'(1) : r_addr + ILS_AW'(1);
        end

        // evaluate the word read in the previous cycle
        if (r_rd_v && r_op == OP_FIND && !r_found && i_mem_rdata == r_value) begin
            r_found  <= 1'b1;
            r_status <= ST_OK;
            r_result <= ILS_DW'(r_rd_a);
        end
        if (r_rd_v && r_op == OP_REM && rem_hit) begin
            r_result <= i_mem_rdata;
        end

        if (i_cmd.out_load) begin
            r_out_value  <= r_result;
            r_out_status <= r_status;
            r_out_count  <= cnt[ILS_NW-1:0];
        end
    end

    // shift writes follow each read in the next cycle
    always_comb begin
        o_mem_we    = 1'b0;
        o_mem_waddr = r_rd_a;
        o_mem_wdata = i_mem_rdata;
        if (i_cmd.place) begin
            o_mem_we    = 1'b1;
            o_mem_waddr = r_epos[ILS_AW-1:0];
            o_mem_wdata = r_value;
        end else if (r_rd_v && r_op == OP_INS) begin
            o_mem_we    = 1'b1;
            o_mem_waddr = r_rd_a + ILS_AW'(1);
        end else if (r_rd_v && r_op == OP_REM && !rem_hit) begin
            o_mem_we    = 1'b1;
            o_mem_waddr = r_rd_a - ILS_AW'(1);
        end
    end

    assign o_mem_re       = i_cmd.rd;
    assign o_mem_raddr    = r_addr;
    assign o_result_value = r_out_value;
    assign o_status       = r_out_status;
    assign o_entry_count  = r_out_count;

endmodule

### rtl/indexed_list_store.sv
// Commands walk the entry RAM at one entry a cycle; a rejected command or an unused kind
//   skips the walk, and so does a push or insert that moves no entries.
// Throughput: one command at a time, the next one is taken once the result is registered.
// Reset: i_rst_n synchronous active low; clears the count and the handshake state.
//   Entry RAM contents are not cleared and are only read below the count.
module indexed_list_store
    import ils_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,  // [6:0] position, [38:7] value, [39] zero
    input  logic [2:0]  i_s_tuser,  // [2:0] kind
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,  // [31:0] result_value, [38:32] entry_count, [39] zero
    output logic [2:0]  o_m_tuser   // [2:0] status
);

    t_cmd              cmd;
    t_dp_stat          stat;
    logic              mem_we;
    logic [ILS_AW-1:0] mem_waddr;
    logic [ILS_DW-1:0] mem_wdata;
    logic              mem_re;
    logic [ILS_AW-1:0] mem_raddr;
    logic [ILS_DW-1:0] mem_rdata;
    logic [ILS_DW-1:0] result_value;
    logic [ILS_NW-1:0] entry_count;

    // Sequence each command: take the transfer, decode, walk the RAM, commit, deliver.
    ils_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Hold the command, count, walk address and the registered result.
    ils_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_kind         (i_s_tuser),
        .i_position     (i_s_tdata[6:0]),
        .i_value        (i_s_tdata[38:7]),
        .o_result_value (result_value),
        .o_status       (o_m_tuser),
        .o_entry_count  (entry_count),
        .o_mem_we       (mem_we),
        .o_mem_waddr    (mem_waddr),
        .o_mem_wdata    (mem_wdata),
        .o_mem_re       (mem_re),
        .o_mem_raddr    (mem_raddr),
        .i_mem_rdata    (mem_rdata)
    );

    // Entry store: one write and one registered read per cycle.
    ils_ram #(
        .WIDTH (ILS_DW),
        .DEPTH (ILS_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_m_tdata = {1'b0, entry_count, result_value};

    // A shift never writes the address it reads in the same cycle.
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("entry RAM read and write at the same address");

    // A failed command or an unmatched find reports a zero value.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != ST_OK) |-> (o_m_tdata[31:0] == '0))
        else $error("nonzero result value with a failing status");

    // The cycle after an input transfer is always the decode step, never a RAM walk.
    a_decode_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (cmd.start && !mem_re && !mem_we))
        else $error("RAM access before decode");

    // A result is registered only when the output register is free.
    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_m_tvalid || i_m_tready))
        else $error("result overwritten while waiting");

endmodule

### tb/sv/indexed_list_store_test.sv
`timescale 1ns / 100ps

module indexed_list_store_test;
    import ils_pkg::*;

    // Kind code that the block treats as a no-op; it has no member in t_kind.
    localparam logic [ILS_KW-1:0] KIND_UNUSED = 3'd7;

    localparam int RANDOM_CMDS  = 1100;
    localparam int CALM_FROM    = 300;    // accepted commands where idling stops
    localparam int CALM_UNTIL   = 500;
    localparam int STALL_AT     = 700;    // accepted commands before the long receive stall
    localparam int STALL_CYCLES = 400;
    localparam int DRAIN_CYCLES = 80;     // settle time after the last result
    localparam int CYCLE_LIMIT  = 600000;

    typedef struct {
        logic [ILS_KW-1:0] kind;
        logic [ILS_PW-1:0] pos;
        logic [ILS_DW-1:0] word;
    } list_cmd_t;

    typedef struct {
        logic [ILS_DW-1:0] value;
        logic [ILS_SW-1:0] status;
        logic [ILS_NW-1:0] count;
    } list_reply_t;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        s_tvalid   = 1'b0;
    logic [39:0] s_tdata    = '0;     // [6:0] position, [38:7] value, [39] zero
    logic [2:0]  s_tuser    = '0;     // [2:0] kind
    logic        m_tready   = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [39:0] o_m_tdata;           // [31:0] result_value, [38:32] entry_count, [39] zero
    logic [2:0]  o_m_tuser;           // [2:0] status

    indexed_list_store DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the list, advanced once per accepted command.
    logic [ILS_DW-1:0] list_words [ILS_DEPTH];
    int                list_len = 0;

    list_cmd_t   cmd_backlog [$];
    list_reply_t awaited_replies [$];
    list_cmd_t   cur_cmd;

    int  n_total      = 0;
    int  items_sent   = 0;
    int  results_seen = 0;
    int  errors       = 0;
    int  cycles       = 0;
    int  peak_count   = 0;
    int  status_hits [5] = '{default: 0};
    int  hold_left    = 0;
    logic hold_done   = 1'b0;
    logic calm;

    // Keep both sides busy in a window so back-to-back commands get exercised.
    assign calm = (items_sent >= CALM_FROM) && (items_sent < CALM_UNTIL);

    // ------------------------------------------------------------------
    // List prediction
    // ------------------------------------------------------------------

    // Shift entries at and after the slot back by one and drop the word in.
    function automatic void open_slot(int at, logic [ILS_DW-1:0] word);
        for (int i = list_len; i > at; i--)
            list_words[i] = list_words[i-1];
        list_words[at] = word;
        list_len++;
    endfunction

    // Take the word out of the slot and close the hole from behind.
    function automatic logic [ILS_DW-1:0] close_slot(int at);
        logic [ILS_DW-1:0] word;
        word = list_words[at];
        for (int i = at; i + 1 < list_len; i++)
            list_words[i] = list_words[i+1];
        list_len--;
        return word;
    endfunction

    function automatic list_reply_t apply_list_cmd(list_cmd_t c);
        list_reply_t r;
        r.value  = '0;
        r.status = ST_OK;
        case (c.kind)
            K_PUSH_FRONT, K_PUSH_REAR: begin
                if (list_len >= ILS_DEPTH)
                    r.status = ST_FULL;
                else
                    open_slot((c.kind == K_PUSH_FRONT) ? 0 : list_len, c.word);
            end
            K_INSERT_AT: begin
                // position check wins over the full check
                if (int'(c.pos) > list_len)
                    r.status = ST_BAD_POS;
                else if (list_len >= ILS_DEPTH)
                    r.status = ST_FULL;
                else
                    open_slot(int'(c.pos), c.word);
            end
            K_POP_FRONT, K_POP_REAR: begin
                if (list_len == 0)
                    r.status = ST_EMPTY;
                else
                    r.value = close_slot((c.kind == K_POP_FRONT) ? 0 : list_len - 1);
            end
            K_REMOVE_AT: begin
                if (list_len == 0)
                    r.status = ST_EMPTY;
                else if (int'(c.pos) >= list_len)
                    r.status = ST_BAD_POS;
                else
                    r.value = close_slot(int'(c.pos));
            end
            K_FIND: begin
                r.status = ST_NOT_FOUND;
                for (int i = 0; i < list_len; i++) begin
                    if (list_words[i] == c.word) begin
                        r.value  = 32'(i);
                        r.status = ST_OK;
                        break;
                    end
                end
            end
            default: ;  // unused kind: no change, ok, zero
        endcase
        r.count = list_len[ILS_NW-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------

    int gen_fill = 0;  // entry count the generated sequence will have reached

    // Queue one command and track how it moves the count, so the random phases
    // can steer the list between empty and full.
    task automatic add_cmd(logic [ILS_KW-1:0] kind, logic [ILS_PW-1:0] pos,
                           logic [ILS_DW-1:0] word);
        list_cmd_t c;
        c.kind = kind;
        c.pos  = pos;
        c.word = word;
        cmd_backlog.push_back(c);
        n_total++;
        case (kind)
            K_PUSH_FRONT, K_PUSH_REAR: if (gen_fill < ILS_DEPTH) gen_fill++;
            K_INSERT_AT: if (int'(pos) <= gen_fill && gen_fill < ILS_DEPTH) gen_fill++;
            K_POP_FRONT, K_POP_REAR: if (gen_fill > 0) gen_fill--;
            K_REMOVE_AT: if (gen_fill > 0 && int'(pos) < gen_fill) gen_fill--;
            default: ;
        endcase
    endtask

    // Favor a small pool of words so finds hit and duplicates appear.
    function automatic logic [ILS_DW-1:0] pick_word();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 32'($urandom_range(0, 15));
        if (roll < 60) begin
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7fff_ffff;
                2:       return 32'hffff_ffff;
                default: return 32'h0000_0000;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [ILS_PW-1:0] any_pos();
        return 7'($urandom_range(0, 127));
    endfunction

    function automatic logic [ILS_KW-1:0] any_kind();
        return 3'($urandom_range(0, 7));
    endfunction

    initial begin
        int               roll;
        int               phase;
        logic [ILS_KW-1:0] k;

        // Directed: empty-list errors, extreme words, edge positions, unused kind.
        add_cmd(K_POP_FRONT,  7'd0,   32'h0);
        add_cmd(K_POP_REAR,   7'd0,   32'h0);
        add_cmd(K_REMOVE_AT,  7'd0,   32'h0);
        add_cmd(K_FIND,       7'd0,   32'h0);
        add_cmd(KIND_UNUSED,  7'd127, 32'hffff_ffff);
        add_cmd(K_INSERT_AT,  7'd1,   32'h5);
        add_cmd(K_INSERT_AT,  7'd0,   32'h8000_0000);
        add_cmd(K_PUSH_REAR,  7'd0,   32'h7fff_ffff);
        add_cmd(K_PUSH_FRONT, 7'd127, 32'h0);
        add_cmd(K_INSERT_AT,  7'd3,   32'hffff_ffff);   // position equal to count
        add_cmd(K_INSERT_AT,  7'd2,   32'h1);
        add_cmd(K_FIND,       7'd0,   32'h7fff_ffff);
        add_cmd(K_FIND,       7'd0,   32'h1234_5678);
        add_cmd(K_REMOVE_AT,  7'd127, 32'h0);
        add_cmd(K_REMOVE_AT,  7'd5,   32'h0);           // position equal to count
        add_cmd(K_INSERT_AT,  7'd127, 32'hdead_beef);
        add_cmd(K_REMOVE_AT,  7'd1,   32'h0);
        add_cmd(K_POP_FRONT,  7'd0,   32'h0);
        add_cmd(K_POP_REAR,   7'd0,   32'h0);
        add_cmd(KIND_UNUSED,  7'd0,   32'h0);
        add_cmd(K_PUSH_FRONT, 7'd0,   32'hffff_ffff);
        add_cmd(K_FIND,       7'd0,   32'hffff_ffff);   // matches the entry at the front
        add_cmd(K_REMOVE_AT,  7'd0,   32'h0);

        // Random: cycle through filling, draining and mixed phases.
        phase = 0;
        while (n_total < RANDOM_CMDS + 23) begin
            case (phase % 3)
                0: begin
                    while (gen_fill < ILS_DEPTH) begin
                        roll = $urandom_range(0, 99);
                        if (roll < 80) begin
                            case ($urandom_range(0, 2))
                                0:       k = K_PUSH_FRONT;
                                1:       k = K_PUSH_REAR;
                                default: k = K_INSERT_AT;
                            endcase
                            add_cmd(k, 7'($urandom_range(0, gen_fill)), pick_word());
                        end else if (roll < 90)
                            add_cmd(K_FIND, any_pos(), pick_word());
                        else
                            add_cmd(any_kind(), any_pos(), pick_word());
                    end
                    // knock on the full list
                    add_cmd(K_PUSH_FRONT, any_pos(), pick_word());
                    add_cmd(K_PUSH_REAR, any_pos(), pick_word());
                    add_cmd(K_INSERT_AT, 7'($urandom_range(0, ILS_DEPTH)), pick_word());
                    add_cmd(K_INSERT_AT, 7'($urandom_range(ILS_DEPTH + 1, 127)), pick_word());
                    add_cmd(K_FIND, any_pos(), pick_word());
                end
                1: begin
                    while (gen_fill > 0) begin
                        roll = $urandom_range(0, 99);
                        if (roll < 80) begin
                            case ($urandom_range(0, 2))
                                0:       k = K_POP_FRONT;
                                1:       k = K_POP_REAR;
                                default: k = K_REMOVE_AT;
                            endcase
                            add_cmd(k, 7'($urandom_range(0, gen_fill - 1)), pick_word());
                        end else if (roll < 90)
                            add_cmd(K_FIND, any_pos(), pick_word());
                        else
                            add_cmd(any_kind(), any_pos(), pick_word());
                    end
                    // knock on the empty list
                    add_cmd(K_POP_FRONT, any_pos(), pick_word());
                    add_cmd(K_POP_REAR, any_pos(), pick_word());
                    add_cmd(K_REMOVE_AT, any_pos(), pick_word());
                    add_cmd(K_FIND, any_pos(), pick_word());
                end
                default: begin
                    repeat (60) begin
                        if ($urandom_range(0, 99) < 80)
                            add_cmd(any_kind(), 7'($urandom_range(0, gen_fill + 1)),
                                    pick_word());
                        else
                            add_cmd(any_kind(), any_pos(), pick_word());
                    end
                end
            endcase
            phase++;
        end
    end

    // Hold reset for the first cycles, then release for good.
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Command driver
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end else if (!s_tvalid || o_s_tready) begin
            // A transfer just completed: advance the shadow list now.
            if (s_tvalid) begin
                awaited_replies.push_back(apply_list_cmd(cur_cmd));
                items_sent <= items_sent + 1;
            end
            // Offer the next command, or idle this cycle.
            if (cmd_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 9)) begin
                cur_cmd = cmd_backlog.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {1'b0, cur_cmd.word, cur_cmd.pos};
                s_tuser  <= cur_cmd.kind;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random back-pressure plus one long hold-off
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (!hold_done && items_sent >= STALL_AT) begin
            // Hold off while the driver keeps offering, so the input stalls.
            hold_left <= STALL_CYCLES;
            hold_done <= 1'b1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(0, 99) >= 9);
        end
    end

    always @(posedge i_clk) begin
        list_reply_t want;
        if (i_rst_n && o_m_tvalid && m_tready) begin
            results_seen <= results_seen + 1;
            if (awaited_replies.size() == 0) begin
                errors++;
                $display("%0t: result with none expected: value %h status %0d count %0d",
                         $time, o_m_tdata[31:0], o_m_tuser, o_m_tdata[38:32]);
            end else begin
                want = awaited_replies.pop_front();
                if (o_m_tdata[31:0] !== want.value) begin
                    errors++;
                    $display("%0t: result_value expected %h actual %h",
                             $time, want.value, o_m_tdata[31:0]);
                end
                if (o_m_tuser !== want.status) begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_m_tuser);
                end
                if (o_m_tdata[38:32] !== want.count) begin
                    errors++;
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, want.count, o_m_tdata[38:32]);
                end
                if (o_m_tdata[39] !== 1'b0) begin
                    errors++;
                    $display("%0t: tdata pad bit expected 0 actual %b", $time, o_m_tdata[39]);
                end
                if (want.status <= ST_NOT_FOUND)
                    status_hits[want.status]++;
                if (int'(want.count) > peak_count)
                    peak_count = int'(want.count);
            end
        end
    end

    // Abort if the run hangs.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d of %0d commands taken, %0d results pending",
                     $time, items_sent, n_total, awaited_replies.size());
            $display("indexed_list_store_test: errors");
            $finish;
        end
    end

    // Wait for every command to be taken and answered, then let the block settle.
    initial begin
        @(posedge i_rst_n);
        while (items_sent < n_total || awaited_replies.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (awaited_replies.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived", $time, awaited_replies.size());
        end
        $display("ran %0d list commands through %0d results, peak %0d entries",
                 n_total, results_seen, peak_count);
        $display("outcomes: ok %0d, full %0d, empty %0d, bad position %0d, not found %0d",
                 status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_EMPTY],
                 status_hits[ST_BAD_POS], status_hits[ST_NOT_FOUND]);
        if (errors == 0)
            $display("indexed_list_store_test: clean");
        else
            $display("indexed_list_store_test: errors");
        $finish;
    end

endmodule
